/* rtl/core/ipv4ov_pkg.sv */
// Shared types and constants for the IPv4 option list validator.
// Holds option type codes, seen-mask bits and the result record layout.
// No dependencies.
package ipv4ov_pkg;

  // Option type codes (first byte of an option).
  localparam logic [7:0] OPT_EOL  = 8'h00;
  localparam logic [7:0] OPT_NOP  = 8'h01;
  localparam logic [7:0] OPT_RR   = 8'h07;
  localparam logic [7:0] OPT_TS   = 8'h44;
  localparam logic [7:0] OPT_LSRR = 8'h83;
  localparam logic [7:0] OPT_SSRR = 8'h89;
  localparam logic [7:0] OPT_RA   = 8'h94;

  // Bits of the mask of options already seen in this buffer.
  localparam logic [3:0] SEEN_SR = 4'h1;
  localparam logic [3:0] SEEN_TS = 4'h2;
  localparam logic [3:0] SEEN_RR = 4'h4;
  localparam logic [3:0] SEEN_RA = 4'h8;

  // Timestamp flag values that select the entry size.
  localparam logic [3:0] TS_FLAG_TS_ONLY  = 4'h0;
  localparam logic [3:0] TS_FLAG_ADDR     = 4'h1;
  localparam logic [3:0] TS_FLAG_PRESPEC  = 4'h3;

  // Result record; status sits in the lowest bit once packed.
  typedef struct packed {
    logic [5:0] bytes_to_copy;
    logic [5:0] first_hop_offset;
    logic       status;
  } result_t;

  // Mask bit for an option type, zero for types that are not supported.
  function automatic logic [3:0] seen_bit(input logic [7:0] t);
    logic [3:0] r;
    r = 4'h0;
    case (t)
      OPT_LSRR, OPT_SSRR: r = SEEN_SR;
      OPT_TS:             r = SEEN_TS;
      OPT_RR:             r = SEEN_RR;
      OPT_RA:             r = SEEN_RA;
      default:            r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ipv4_option_list_validator_core.sv */
// IPv4 option list validator, top level and only module.
// Scans an option buffer one byte per transaction and reports one result per buffer.
// Depends on ipv4ov_pkg.
//
// Result: when the transaction carrying the last byte is accepted, the buffer's
// result is registered in the result register, or in the skid stage if one waits.
// Throughput: one byte per cycle while the skid stage is empty; the per-byte checks
// sit between the scan state registers and the result register, so nothing iterates.
// A result register plus one skid stage let input continue while a result waits.
// Reset: rst is synchronous and active high; it clears the scan state and empties
// the result and skid registers.
module ipv4_option_list_validator_core
  import ipv4ov_pkg::*;
#(
  parameter int MAX_OPTIONS_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side: one option byte per transaction.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] option_byte, [15:8] buffer_length
  input  logic        s_tlast,   // last_of_buffer
  // Master side: one result per buffer.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] status, [6:1] first_hop_offset,
                                 // [12:7] bytes_to_copy, [15:13] zero
);

  // Scan state. It is cleared after every buffer's last byte.
  logic [7:0] buffer_position;
  logic [5:0] option_start;
  logic [7:0] byte_in_option;
  logic [7:0] current_type;
  logic [7:0] current_length;
  logic [7:0] pointer_value;
  logic [3:0] seen_mask;
  logic       error_flag;
  logic       stopped_flag;
  logic [5:0] hop_offset;
  logic [5:0] consumed_count;

  logic [7:0] buffer_position_next;
  logic [5:0] option_start_next;
  logic [7:0] byte_in_option_next;
  logic [7:0] current_type_next;
  logic [7:0] current_length_next;
  logic [7:0] pointer_value_next;
  logic [3:0] seen_mask_next;
  logic       error_flag_next;
  logic       stopped_flag_next;
  logic [5:0] hop_offset_next;
  logic [5:0] consumed_count_next;

  // Result register and skid stage.
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  result_t new_result;

  logic [7:0] opt_byte;
  logic [7:0] buf_len;
  logic       accept;
  logic       len_ok;
  logic       out_free;

  assign opt_byte = s_tdata[7:0];
  assign buf_len  = s_tdata[15:8];
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign len_ok   = (buf_len >= 8'd2) && (buf_len <= 8'(MAX_OPTIONS_BYTES));
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {3'b000, out_reg};

  // Per-byte scan. The option bytes are handled by their place inside the
  // option: type, length, pointer, and for timestamps the flag byte.
  always_comb begin
    logic [7:0] t;
    logic [7:0] ol;
    logic [7:0] data;
    logic [7:0] entry_mask;
    logic [7:0] room;
    logic       advance;

    buffer_position_next = buffer_position;
    option_start_next    = option_start;
    byte_in_option_next  = byte_in_option;
    current_type_next    = current_type;
    current_length_next  = current_length;
    pointer_value_next   = pointer_value;
    seen_mask_next       = seen_mask;
    error_flag_next      = error_flag;
    stopped_flag_next    = stopped_flag;
    hop_offset_next      = hop_offset;
    consumed_count_next  = consumed_count;

    t          = current_type;
    ol         = current_length;
    data       = 8'd0;
    entry_mask = 8'd3;
    room       = buf_len - {2'b00, option_start};
    advance    = 1'b0;

    if (buf_len != 8'd0) begin
      if (buffer_position != 8'hFF) begin
        buffer_position_next = buffer_position + 8'd1;
      end
      if (len_ok && (buffer_position < buf_len) && !error_flag && !stopped_flag) begin
        consumed_count_next = buffer_position[5:0] + 6'd1;
        if (byte_in_option == 8'd0) begin
          if (opt_byte == OPT_NOP) begin
            // Padding byte, nothing to check.
          end else if (opt_byte == OPT_EOL) begin
            stopped_flag_next = 1'b1;
          end else if (({1'b0, buffer_position} + 9'd1 >= {1'b0, buf_len}) ||
                       (seen_bit(opt_byte) == 4'h0)) begin
            error_flag_next = 1'b1;
          end else begin
            current_type_next   = opt_byte;
            option_start_next   = buffer_position[5:0];
            byte_in_option_next = 8'd1;
          end
        end else if (byte_in_option == 8'd1) begin
          current_length_next = opt_byte;
          ol = opt_byte;
          if ((opt_byte > room) || ((seen_mask & seen_bit(t)) != 4'h0)) begin
            error_flag_next = 1'b1;
          end else if (t == OPT_RA) begin
            if (opt_byte != 8'd4) begin
              error_flag_next = 1'b1;
            end else begin
              seen_mask_next = seen_mask | SEEN_RA;
              advance = 1'b1;
            end
          end else if (t == OPT_TS) begin
            if (opt_byte < 8'd4) error_flag_next = 1'b1;
            else advance = 1'b1;
          end else begin
            // Route options: at least one address, whole 4-byte addresses.
            data = opt_byte - 8'd3;
            if ((opt_byte < 8'd7) || (data[1:0] != 2'b00)) error_flag_next = 1'b1;
            else advance = 1'b1;
          end
        end else if (byte_in_option == 8'd2) begin
          pointer_value_next = opt_byte;
          if ((t != OPT_TS) && (t != OPT_RA)) begin
            data = ol - 8'd3;
            if ((opt_byte < 8'd4) || (opt_byte[1:0] != 2'b00) ||
                (data < opt_byte - 8'd4)) begin
              error_flag_next = 1'b1;
            end else begin
              // Source routes with hops left point at the next hop address.
              if ((t != OPT_RR) && (data > opt_byte - 8'd4)) begin
                hop_offset_next = opt_byte[5:0] - 6'd1 + option_start;
              end
              seen_mask_next = seen_mask | seen_bit(t);
              advance = 1'b1;
            end
          end else begin
            advance = 1'b1;
          end
        end else if ((byte_in_option == 8'd3) && (t == OPT_TS)) begin
          data = ol - 8'd4;
          if ((opt_byte[3:0] == TS_FLAG_ADDR) || (opt_byte[3:0] == TS_FLAG_PRESPEC)) begin
            entry_mask = 8'd7;
          end else begin
            entry_mask = 8'd3;
          end
          if ((opt_byte[3:0] != TS_FLAG_TS_ONLY) && (opt_byte[3:0] != TS_FLAG_ADDR) &&
              (opt_byte[3:0] != TS_FLAG_PRESPEC)) begin
            error_flag_next = 1'b1;
          end else if ((data <= entry_mask) || ((data & entry_mask) != 8'd0) ||
                       (pointer_value < 8'd5) ||
                       (((pointer_value - 8'd5) & entry_mask) != 8'd0) ||
                       (data < pointer_value - 8'd5)) begin
            error_flag_next = 1'b1;
          end else begin
            seen_mask_next = seen_mask | SEEN_TS;
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end

        if (advance) begin
          if (byte_in_option + 8'd1 >= ol) byte_in_option_next = 8'd0;
          else byte_in_option_next = byte_in_option + 8'd1;
        end
      end
    end
  end

  // Result for a buffer whose last byte is being accepted.
  always_comb begin
    new_result = '0;
    if (buf_len == 8'd0) begin
      new_result = '0;
    end else if (!len_ok) begin
      new_result.status = 1'b1;
    end else if (error_flag_next ||
                 (!stopped_flag_next && (buffer_position_next < buf_len))) begin
      new_result.status           = 1'b1;
      new_result.first_hop_offset = hop_offset_next;
    end else begin
      new_result.first_hop_offset = hop_offset_next;
      new_result.bytes_to_copy    = consumed_count_next;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      buffer_position <= '0;
      option_start    <= '0;
      byte_in_option  <= '0;
      current_type    <= '0;
      current_length  <= '0;
      pointer_value   <= '0;
      seen_mask       <= '0;
      error_flag      <= 1'b0;
      stopped_flag    <= 1'b0;
      hop_offset      <= '0;
      consumed_count  <= '0;
    end else if (accept) begin
      buffer_position <= buffer_position_next;
      option_start    <= option_start_next;
      byte_in_option  <= byte_in_option_next;
      current_type    <= current_type_next;
      current_length  <= current_length_next;
      pointer_value   <= pointer_value_next;
      seen_mask       <= seen_mask_next;
      error_flag      <= error_flag_next;
      stopped_flag    <= stopped_flag_next;
      hop_offset      <= hop_offset_next;
      consumed_count  <= consumed_count_next;
    end
  end

  // Output register with one skid stage. Input stalls only while the skid
  // stage holds a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && s_tlast) begin
      if (out_free) m_tvalid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) out_reg <= skid_reg;
    end else if (accept && s_tlast) begin
      if (out_free) out_reg <= new_result;
      else skid_reg <= new_result;
    end
  end

  // The skid stage only fills behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_tvalid)
    else $error("skid stage holds a result while the output is empty");

  // An invalid buffer never reports bytes to copy.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reg.status) |-> (out_reg.bytes_to_copy == 6'd0))
    else $error("bytes_to_copy nonzero on an invalid result");

  // Scan state is clear after a buffer closes.
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> ((buffer_position == 8'd0) && (seen_mask == 4'h0) &&
                             !error_flag && !stopped_flag))
    else $error("scan state not cleared after the last byte");

  // The position inside an option stays below the option length once that length is read.
  assert property (@(posedge clk) disable iff (rst)
    (byte_in_option != 8'd0) |-> ((byte_in_option < current_length) ||
                                  (byte_in_option == 8'd1)))
    else $error("byte_in_option ran past the option length");

endmodule
